FILE: rtl/core/tsq_pkg.sv
// Shared constants for the touch sample qualifier: register indexes, reset
// values, result codes and field widths.
// No dependencies.
package tsq_pkg;

	// Default coordinate width of the controller
	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths
	localparam int SIZE_BITS    = 12;
	localparam int CONFIRM_BITS = 8;
	localparam int STAMP_BITS   = 32;
	localparam int COUNT_BITS   = 4;
	localparam int REG_IDX_BITS = 3;
	localparam int CFG_BITS     = 12;
	localparam int S_DATA_BITS  = 72;
	localparam int M_DATA_BITS  = 96;

	// Register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_NATIVE_WIDTH    = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_NATIVE_HEIGHT   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_ROTATION        = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_INVERT_X        = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_INVERT_Y        = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_CONFIRM = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_JUMP_THRESHOLD  = 3'd6;

	// Register reset values
	localparam logic [SIZE_BITS-1:0]    RST_NATIVE_WIDTH    = 12'd320;
	localparam logic [SIZE_BITS-1:0]    RST_NATIVE_HEIGHT   = 12'd480;
	localparam logic [CONFIRM_BITS-1:0] RST_RELEASE_CONFIRM = 8'd2;
	localparam logic [SIZE_BITS-1:0]    RST_JUMP_THRESHOLD  = 12'd60;

	// Contact count limit
	localparam logic [COUNT_BITS-1:0] MAX_POINTS = 4'd2;

	// Rotation codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// Event codes
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_DOWN = 2'd1;
	localparam logic [1:0] EV_UP   = 2'd2;

	// Sample classes
	localparam logic [1:0] CLS_OK    = 2'd0;
	localparam logic [1:0] CLS_BUS   = 2'd1;
	localparam logic [1:0] CLS_COUNT = 2'd2;
	localparam logic [1:0] CLS_RANGE = 2'd3;

endpackage

FILE: rtl/core/touch_sample_qualifier.sv
// Touch sample qualifier top level: input register, qualification and
// screen mapping logic, result register. Depends on tsq_pkg.
//
// Usage: each status burst read from the touch controller enters on the
// s_* stream (s_tuser carries the bus-read flag). The block rejects failed
// reads, contact counts above two and points outside the panel, tracks the
// confirmed contact state with a release debounce, flags jumps and bridged
// dropouts, and returns one result per request on the m_* stream
// (m_tuser: sample class). Each result holds the held raw point and
// that point rotated, mirrored and clamped to the screen.
// A request is captured in the input register, then moves into the result
// register once that slot is free and is held there until it is taken.
// Throughput: one request per cycle while the receiver takes results, set
// by the single qualification pass between the two registers; contact
// state updates as an item leaves the input register.
// Reset: configuration returns to its defaults (320 x 480, no rotation,
// release after 2 empty samples, jump limit 60) and contact state clears.
// When the receiver stalls, the result register holds, the input register
// still takes one more request, and s_tready then drops until the result
// is taken. Configuration writes on wr_* take effect at once; the user must
// make them while no request is in flight; the block does not enforce this.
module touch_sample_qualifier #(
	parameter int COORD_BITS = tsq_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write port
	input  logic                                   wr_en,
	input  logic [tsq_pkg::REG_IDX_BITS-1:0]       wr_index,
	input  logic [tsq_pkg::CFG_BITS-1:0]           wr_data,
	// Sample input stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// status_byte, x_high, x_low, y_high, y_low, time_us
	input  logic [tsq_pkg::S_DATA_BITS-1:0]        s_tdata,
	// read_ok
	input  logic                                   s_tuser,
	// Result output stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// event_res, jump_seen, dropout_bridged, touching, point_count, raw_x,
	// raw_y, screen_x, screen_y, down_time, zero pad
	output logic [tsq_pkg::M_DATA_BITS-1:0]        m_tdata,
	// sample_class
	output logic [1:0]                             m_tuser
);

	localparam int SB = tsq_pkg::SIZE_BITS;
	localparam int MW = (COORD_BITS > SB) ? COORD_BITS : SB;
	localparam int SW = MW + 3;
	localparam int PAD_BITS = tsq_pkg::M_DATA_BITS - 89;

	// Configuration registers
	logic [SB-1:0]                      native_width_q;
	logic [SB-1:0]                      native_height_q;
	logic [1:0]                         rotation_q;
	logic                               invert_x_q;
	logic                               invert_y_q;
	logic [tsq_pkg::CONFIRM_BITS-1:0]   release_confirm_q;
	logic [SB-1:0]                      jump_threshold_q;

	// Contact state
	logic                               held_q;
	logic [tsq_pkg::CONFIRM_BITS-1:0]   empty_q;
	logic [COORD_BITS-1:0]              hx_q;
	logic [COORD_BITS-1:0]              hy_q;
	logic [tsq_pkg::STAMP_BITS-1:0]     stamp_q;

	// Input register
	logic                               valid_s1;
	logic                               ok_s1;
	logic [tsq_pkg::COUNT_BITS-1:0]     count_s1;
	logic [COORD_BITS-1:0]              x_s1;
	logic [COORD_BITS-1:0]              y_s1;
	logic [tsq_pkg::STAMP_BITS-1:0]     time_s1;

	// Result register
	logic                               valid_s2;
	logic [1:0]                         ev_s2;
	logic [1:0]                         cls_s2;
	logic                               jump_s2;
	logic                               drop_s2;
	logic                               touch_s2;
	logic [tsq_pkg::COUNT_BITS-1:0]     pc_s2;
	logic [SB-1:0]                      rx_s2;
	logic [SB-1:0]                      ry_s2;
	logic [SB-1:0]                      sx_s2;
	logic [SB-1:0]                      sy_s2;
	logic [tsq_pkg::STAMP_BITS-1:0]     down_s2;

	// Next-state and result logic
	logic                               advance;
	logic                               held_n;
	logic [tsq_pkg::CONFIRM_BITS-1:0]   empty_n;
	logic [tsq_pkg::CONFIRM_BITS-1:0]   empty_inc;
	logic [COORD_BITS-1:0]              hx_n;
	logic [COORD_BITS-1:0]              hy_n;
	logic [tsq_pkg::STAMP_BITS-1:0]     stamp_n;
	logic [1:0]                         ev_n;
	logic [1:0]                         cls_n;
	logic                               jump_n;
	logic                               drop_n;
	logic [tsq_pkg::COUNT_BITS-1:0]     pc_n;
	logic                               out_range;
	logic [COORD_BITS-1:0]              dx;
	logic [COORD_BITS-1:0]              dy;
	logic signed [SW-1:0]               nw_s;
	logic signed [SW-1:0]               nh_s;
	logic signed [SW-1:0]               px_s;
	logic signed [SW-1:0]               py_s;
	logic signed [SW-1:0]               mx;
	logic signed [SW-1:0]               my;
	logic signed [SW-1:0]               mx_i;
	logic signed [SW-1:0]               my_i;
	logic [SB-1:0]                      sw;
	logic [SB-1:0]                      sh;
	logic [SB-1:0]                      sx_n;
	logic [SB-1:0]                      sy_n;

	// Clamp a mapped coordinate to [0, size-1]; a zero size gives zero
	function automatic logic [SB-1:0] clamp_axis(input logic signed [SW-1:0] v,
		input logic [SB-1:0] size);
		logic signed [SW-1:0] size_s;
		logic [SB-1:0]        res;
		size_s = $signed(SW'(size));
		if (size == '0) begin
			res = '0;
		end else if (v < 0) begin
			res = '0;
		end else if (v >= size_s) begin
			res = size - SB'(1);
		end else begin
			res = v[SB-1:0];
		end
		return res;
	endfunction

	// Move an item out of the input register when the result slot frees
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Hold configuration; write one register per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_width_q    <= tsq_pkg::RST_NATIVE_WIDTH;
			native_height_q   <= tsq_pkg::RST_NATIVE_HEIGHT;
			rotation_q        <= tsq_pkg::ROT_0;
			invert_x_q        <= 1'b0;
			invert_y_q        <= 1'b0;
			release_confirm_q <= tsq_pkg::RST_RELEASE_CONFIRM;
			jump_threshold_q  <= tsq_pkg::RST_JUMP_THRESHOLD;
		end else if (wr_en) begin
			unique case (wr_index)
				tsq_pkg::REG_NATIVE_WIDTH:    native_width_q    <= wr_data;
				tsq_pkg::REG_NATIVE_HEIGHT:   native_height_q   <= wr_data;
				tsq_pkg::REG_ROTATION:        rotation_q        <= wr_data[1:0];
				tsq_pkg::REG_INVERT_X:        invert_x_q        <= wr_data[0];
				tsq_pkg::REG_INVERT_Y:        invert_y_q        <= wr_data[0];
				tsq_pkg::REG_RELEASE_CONFIRM: release_confirm_q <= wr_data[7:0];
				tsq_pkg::REG_JUMP_THRESHOLD:  jump_threshold_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Capture the request into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ok_s1    <= s_tuser;
			count_s1 <= s_tdata[3:0];
			x_s1     <= COORD_BITS'({s_tdata[15:8], s_tdata[23:16]});
			y_s1     <= COORD_BITS'({s_tdata[31:24], s_tdata[39:32]});
			time_s1  <= s_tdata[71:40];
		end
	end

	// Qualify the sample and work out the next contact state
	always_comb begin
		empty_inc = (empty_q == '1) ? empty_q : empty_q + 1'b1;
		out_range = (MW'(x_s1) >= MW'(native_width_q)) ||
			(MW'(y_s1) >= MW'(native_height_q));
		dx = (x_s1 > hx_q) ? x_s1 - hx_q : hx_q - x_s1;
		dy = (y_s1 > hy_q) ? y_s1 - hy_q : hy_q - y_s1;
		held_n  = held_q;
		empty_n = empty_q;
		hx_n    = hx_q;
		hy_n    = hy_q;
		stamp_n = stamp_q;
		ev_n    = tsq_pkg::EV_NONE;
		cls_n   = tsq_pkg::CLS_OK;
		jump_n  = 1'b0;
		drop_n  = 1'b0;
		pc_n    = count_s1;
		priority if (!ok_s1) begin
			cls_n = tsq_pkg::CLS_BUS;
			pc_n  = '0;
		end else if (count_s1 > tsq_pkg::MAX_POINTS) begin
			cls_n = tsq_pkg::CLS_COUNT;
		end else if (count_s1 == '0) begin
			// Count empty samples while held; release once confirmed
			if (held_q) begin
				if (empty_inc >= release_confirm_q) begin
					held_n  = 1'b0;
					empty_n = '0;
					ev_n    = tsq_pkg::EV_UP;
				end else begin
					empty_n = empty_inc;
				end
			end else begin
				empty_n = '0;
			end
		end else if (out_range) begin
			cls_n = tsq_pkg::CLS_RANGE;
		end else begin
			drop_n  = held_q && (empty_q != '0);
			empty_n = '0;
			if (held_q) begin
				jump_n = (MW'(dx) > MW'(jump_threshold_q)) ||
					(MW'(dy) > MW'(jump_threshold_q));
			end else begin
				held_n  = 1'b1;
				stamp_n = time_s1;
				ev_n    = tsq_pkg::EV_DOWN;
			end
			hx_n = x_s1;
			hy_n = y_s1;
		end
	end

	// Rotate, mirror and clamp the held point
	always_comb begin
		nw_s = $signed(SW'(native_width_q));
		nh_s = $signed(SW'(native_height_q));
		px_s = $signed(SW'(hx_n));
		py_s = $signed(SW'(hy_n));
		unique case (rotation_q)
			tsq_pkg::ROT_0: begin
				mx = px_s;
				my = py_s;
			end
			tsq_pkg::ROT_90: begin
				mx = py_s;
				my = nw_s - SW'(1) - px_s;
			end
			tsq_pkg::ROT_180: begin
				mx = nw_s - SW'(1) - px_s;
				my = nh_s - SW'(1) - py_s;
			end
			tsq_pkg::ROT_270: begin
				mx = nh_s - SW'(1) - py_s;
				my = px_s;
			end
		endcase
		sw   = rotation_q[0] ? native_height_q : native_width_q;
		sh   = rotation_q[0] ? native_width_q : native_height_q;
		mx_i = invert_x_q ? $signed(SW'(sw)) - SW'(1) - mx : mx;
		my_i = invert_y_q ? $signed(SW'(sh)) - SW'(1) - my : my;
		sx_n = clamp_axis(mx_i, sw);
		sy_n = clamp_axis(my_i, sh);
	end

	// Advance contact state as an item is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			empty_q <= '0;
			hx_q    <= '0;
			hy_q    <= '0;
			stamp_q <= '0;
		end else if (advance) begin
			held_q  <= held_n;
			empty_q <= empty_n;
			hx_q    <= hx_n;
			hy_q    <= hy_n;
			stamp_q <= stamp_n;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_s2    <= ev_n;
			cls_s2   <= cls_n;
			jump_s2  <= jump_n;
			drop_s2  <= drop_n;
			touch_s2 <= held_n;
			pc_s2    <= pc_n;
			rx_s2    <= MW'(hx_n) & MW'({SB{1'b1}});
			ry_s2    <= MW'(hy_n) & MW'({SB{1'b1}});
			sx_s2    <= sx_n;
			sy_s2    <= sy_n;
			down_s2  <= stamp_n;
		end
	end

	// Pack the result
	assign m_tvalid = valid_s2;
	assign m_tuser  = cls_s2;
	assign m_tdata  = {{PAD_BITS{1'b0}}, down_s2, sy_s2, sx_s2, ry_s2, rx_s2, pc_s2,
		touch_s2, drop_s2, jump_s2, ev_s2};

`ifndef SYNTH
	// A touch-down result always reports contact held
	a_down_touching: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == tsq_pkg::EV_DOWN) |-> m_tdata[4])
		else $error("touch down reported without contact");

	// A touch-up result always reports contact released
	a_up_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == tsq_pkg::EV_UP) |-> !m_tdata[4])
		else $error("touch up reported with contact held");

	// A rejected sample carries no event, jump or dropout flag
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != tsq_pkg::CLS_OK) |-> (m_tdata[3:0] == 4'd0))
		else $error("rejected sample carries flags");

	// An empty result slot never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result slot");
`endif

endmodule
